// ----- rtl/core/ie16_pkg.sv -----
// shared codes, types and helpers of the 16-bit instruction executor
package ie16_pkg;

	typedef logic [2:0] kind_t;
	typedef logic [2:0] action_t;

	localparam kind_t K_REG = 3'd0;
	localparam kind_t K_SP  = 3'd1;
	localparam kind_t K_PC  = 3'd2;
	localparam kind_t K_O   = 3'd3;
	localparam kind_t K_MEM = 3'd4;
	localparam kind_t K_LIT = 3'd5;

	localparam action_t ACT_MEM_WR = 3'd0;
	localparam action_t ACT_MEM_RD = 3'd1;
	localparam action_t ACT_REG_WR = 3'd2;
	localparam action_t ACT_REG_RD = 3'd3;
	localparam action_t ACT_EXEC   = 3'd4;

	localparam logic [3:0] OP_NB  = 4'h0;
	localparam logic [3:0] OP_SET = 4'h1;
	localparam logic [3:0] OP_ADD = 4'h2;
	localparam logic [3:0] OP_SUB = 4'h3;
	localparam logic [3:0] OP_MUL = 4'h4;
	localparam logic [3:0] OP_DIV = 4'h5;
	localparam logic [3:0] OP_MOD = 4'h6;
	localparam logic [3:0] OP_SHL = 4'h7;
	localparam logic [3:0] OP_SHR = 4'h8;
	localparam logic [3:0] OP_AND = 4'h9;
	localparam logic [3:0] OP_BOR = 4'hA;
	localparam logic [3:0] OP_XOR = 4'hB;
	localparam logic [3:0] OP_IFE = 4'hC;
	localparam logic [3:0] OP_IFN = 4'hD;
	localparam logic [3:0] OP_IFG = 4'hE;
	localparam logic [3:0] OP_IFB = 4'hF;

	localparam logic [5:0] NB_JSR = 6'h01;

	localparam logic [3:0] SEL_PC = 4'd8;
	localparam logic [3:0] SEL_SP = 4'd9;
	localparam logic [3:0] SEL_O  = 4'd10;

	// operand codes that pull a next word
	function automatic logic extra_word(input logic [5:0] code);
		return (code[5:3] == 3'b010) || (code == 6'h1e) || (code == 6'h1f);
	endfunction

endpackage

// ----- rtl/core/dcpu16_instruction_executor.sv -----
// 16-bit processor core with its own word memory, run one item at a time
// memory and register actions step through their own states; an instruction is fetched,
// decoded, reads operands and executes; DIV and MOD with a nonzero divisor add the bit-serial divider steps
// one item at a time, the next transfer is taken once the sequencer is back in idle
// reset: registers clear at once, then a clearing pass writes zero to every memory
// word, one a cycle, while no item is taken
module dcpu16_instruction_executor
	import ie16_pkg::*;
#(
	parameter int MEM_WORDS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  action,
	input  logic [15:0] mem_address,
	input  logic [3:0]  register_select,
	input  logic [15:0] data_value,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] read_value,
	output logic [15:0] program_counter,
	output logic [15:0] overflow_word,
	output logic        skipped_next
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [23:0] MW = 24'(MEM_WORDS);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_CLEAR = 5'd1;
	localparam logic [4:0] ST_MWR   = 5'd2;
	localparam logic [4:0] ST_MRD   = 5'd3;
	localparam logic [4:0] ST_MRD2  = 5'd4;
	localparam logic [4:0] ST_RWR   = 5'd5;
	localparam logic [4:0] ST_RRD   = 5'd6;
	localparam logic [4:0] ST_F0    = 5'd7;
	localparam logic [4:0] ST_F1    = 5'd8;
	localparam logic [4:0] ST_DEC   = 5'd9;
	localparam logic [4:0] ST_NW    = 5'd10;
	localparam logic [4:0] ST_RDA   = 5'd11;
	localparam logic [4:0] ST_RDA2  = 5'd12;
	localparam logic [4:0] ST_RDB   = 5'd13;
	localparam logic [4:0] ST_RDB2  = 5'd14;
	localparam logic [4:0] ST_EXEC  = 5'd15;
	localparam logic [4:0] ST_DIVS  = 5'd16;
	localparam logic [4:0] ST_DIVF  = 5'd17;
	localparam logic [4:0] ST_WB    = 5'd18;
	localparam logic [4:0] ST_SKIP  = 5'd19;
	localparam logic [4:0] ST_SKIP2 = 5'd20;
	localparam logic [4:0] ST_DONE  = 5'd21;

	// address modulo the memory size, for a quotient below 256
	function automatic logic [AW-1:0] wrap(input logic [15:0] a);
		logic [23:0] r;
		r = {8'd0, a};
		for (int k = 7; k >= 0; k--) begin
			if (r >= (MW << k))
				r = r - (MW << k);
		end
		return r[AW-1:0];
	endfunction

	logic [15:0] mem [MEM_WORDS];
	logic [15:0] mem_rdata_q;
	logic [AW-1:0] rd_addr_c, wr_addr_c;
	logic [15:0] wr_data_c;
	logic mem_we_c;

	logic [4:0] state_q;
	logic [AW-1:0] clr_q;
	logic [15:0] gr_q [8];
	logic [15:0] pc_q, sp_q, o_q;
	logic [AW-1:0] addr_q;
	logic [3:0] sel_q;
	logic [15:0] data_q;
	logic [15:0] instr_q;
	logic opb_q;
	kind_t kind_a_q, kind_b_q;
	logic [15:0] idx_a_q, idx_b_q;
	logic [15:0] av_q, bv_q;
	logic [15:0] res_q, onew_q;
	logic wo_q;
	logic [15:0] rv_q;
	logic skip_q;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0] cnt_q;
	logic result_valid_q;
	logic [15:0] read_value_q, program_counter_q, overflow_word_q;
	logic skipped_next_q;

	logic [2:0] gr_sel_c;
	logic [15:0] gr_rd;
	logic [3:0] op;
	logic [5:0] ca, cb, code;
	logic item_xfer;

	assign op = instr_q[3:0];
	assign ca = instr_q[9:4];
	assign cb = instr_q[15:10];
	assign code = opb_q ? cb : ca;
	assign item_stall = (state_q != ST_IDLE);
	assign item_xfer = item_valid && !item_stall;

	always_comb begin
		case (state_q)
			ST_DEC, ST_NW: gr_sel_c = code[2:0];
			ST_RDA:        gr_sel_c = idx_a_q[2:0];
			ST_RDB:        gr_sel_c = idx_b_q[2:0];
			ST_RRD:        gr_sel_c = sel_q[2:0];
			default:       gr_sel_c = 3'd0;
		endcase
	end
	assign gr_rd = gr_q[gr_sel_c];

	// operand decode without a next word, and after it arrives
	kind_t dec_kind;
	logic [15:0] dec_idx;
	logic dec_nw;
	always_comb begin
		dec_kind = K_MEM;
		dec_idx = 16'd0;
		dec_nw = 1'b0;
		if (state_q == ST_NW) begin
			case (code) inside
				[6'h10:6'h17]: dec_idx = 16'(wrap(mem_rdata_q + gr_rd));
				6'h1e:         dec_idx = 16'(wrap(mem_rdata_q));
				default: begin
					dec_kind = K_LIT;
					dec_idx = mem_rdata_q;
				end
			endcase
		end else begin
			case (code) inside
				[6'h00:6'h07]: begin
					dec_kind = K_REG;
					dec_idx = 16'(code[2:0]);
				end
				[6'h08:6'h0f]: dec_idx = 16'(wrap(gr_rd));
				[6'h10:6'h17], 6'h1e, 6'h1f: dec_nw = 1'b1;
				6'h18, 6'h19:  dec_idx = 16'(wrap(sp_q));
				6'h1a:         dec_idx = 16'(wrap(sp_q - 16'd1));
				6'h1b:         dec_kind = K_SP;
				6'h1c:         dec_kind = K_PC;
				6'h1d:         dec_kind = K_O;
				default: begin
					dec_kind = K_LIT;
					dec_idx = 16'(code[4:0]);
				end
			endcase
		end
	end

	function automatic logic [15:0] opnd_val(input kind_t k, input logic [15:0] idx,
			input logic [15:0] g, input logic [15:0] sp, input logic [15:0] pc,
			input logic [15:0] o);
		case (k)
			K_REG:   return g;
			K_SP:    return sp;
			K_PC:    return pc;
			K_O:     return o;
			default: return idx;
		endcase
	endfunction

	// arithmetic for one instruction
	logic [15:0] ex_res, ex_o;
	logic ex_wo, ex_pass;
	logic [16:0] ex_sum;
	logic [31:0] ex_prod;
	logic [47:0] ex_shl;
	logic [31:0] ex_shr;
	logic big_shift;
	always_comb begin
		ex_sum = {1'b0, av_q} + {1'b0, bv_q};
		ex_prod = av_q * bv_q;
		ex_shl = {32'd0, av_q} << bv_q[4:0];
		ex_shr = {av_q, 16'd0} >> bv_q[4:0];
		big_shift = (bv_q[15:5] != 11'd0);
		ex_res = 16'd0;
		ex_o = 16'd0;
		ex_wo = 1'b0;
		ex_pass = 1'b1;
		case (op)
			OP_SET: ex_res = bv_q;
			OP_ADD: begin
				ex_res = ex_sum[15:0];
				ex_o = 16'(ex_sum[16]);
				ex_wo = 1'b1;
			end
			OP_SUB: begin
				ex_res = av_q - bv_q;
				ex_o = (bv_q > av_q) ? 16'hFFFF : 16'd0;
				ex_wo = 1'b1;
			end
			OP_MUL: begin
				ex_res = ex_prod[15:0];
				ex_o = ex_prod[31:16];
				ex_wo = 1'b1;
			end
			OP_DIV: ex_wo = 1'b1;
			OP_SHL: begin
				ex_res = big_shift ? 16'd0 : ex_shl[15:0];
				ex_o = big_shift ? 16'd0 : ex_shl[31:16];
				ex_wo = 1'b1;
			end
			OP_SHR: begin
				ex_res = big_shift ? 16'd0 : ex_shr[31:16];
				ex_o = big_shift ? 16'd0 : ex_shr[15:0];
				ex_wo = 1'b1;
			end
			OP_AND: ex_res = av_q & bv_q;
			OP_BOR: ex_res = av_q | bv_q;
			OP_XOR: ex_res = av_q ^ bv_q;
			OP_IFE: ex_pass = (av_q == bv_q);
			OP_IFN: ex_pass = (av_q != bv_q);
			OP_IFG: ex_pass = (av_q > bv_q);
			OP_IFB: ex_pass = ((av_q & bv_q) != 16'd0);
			default: ex_res = 16'd0;
		endcase
	end

	// one restoring divider step
	logic [16:0] div_t;
	logic div_ge;
	assign div_t = {rem_q, quo_q[31]};
	assign div_ge = (div_t >= {1'b0, bv_q});

	logic [15:0] skip_len;
	assign skip_len = 16'd1 + 16'(extra_word(mem_rdata_q[15:10]))
		+ ((mem_rdata_q[3:0] != OP_NB) ? 16'(extra_word(mem_rdata_q[9:4])) : 16'd0);

	// memory ports
	always_comb begin
		case (state_q)
			ST_F0, ST_DEC, ST_SKIP: rd_addr_c = wrap(pc_q);
			ST_RDA:  rd_addr_c = idx_a_q[AW-1:0];
			ST_RDB:  rd_addr_c = idx_b_q[AW-1:0];
			default: rd_addr_c = addr_q;
		endcase
		mem_we_c = 1'b0;
		wr_addr_c = addr_q;
		wr_data_c = data_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we_c = 1'b1;
				wr_addr_c = clr_q;
				wr_data_c = 16'd0;
			end
			ST_MWR: mem_we_c = 1'b1;
			ST_EXEC: begin
				mem_we_c = (op == OP_NB) && (ca == NB_JSR);
				wr_addr_c = wrap(sp_q - 16'd1);
				wr_data_c = pc_q;
			end
			ST_WB: begin
				mem_we_c = (kind_a_q == K_MEM);
				wr_addr_c = idx_a_q[AW-1:0];
				wr_data_c = res_q;
			end
			default: mem_we_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		mem_rdata_q <= mem[rd_addr_c];
		if (mem_we_c)
			mem[wr_addr_c] <= wr_data_c;
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			addr_q <= wrap(mem_address);
			sel_q <= register_select;
			data_q <= data_value;
		end
		if (state_q == ST_F1)
			instr_q <= mem_rdata_q;
		if ((state_q == ST_DEC && !dec_nw) || state_q == ST_NW) begin
			if (opb_q) begin
				kind_b_q <= dec_kind;
				idx_b_q <= dec_idx;
			end else begin
				kind_a_q <= dec_kind;
				idx_a_q <= dec_idx;
			end
		end
		if (state_q == ST_RDA)
			av_q <= opnd_val(kind_a_q, idx_a_q, gr_rd, sp_q, pc_q, o_q);
		if (state_q == ST_RDA2)
			av_q <= mem_rdata_q;
		if (state_q == ST_RDB)
			bv_q <= opnd_val(kind_b_q, idx_b_q, gr_rd, sp_q, pc_q, o_q);
		if (state_q == ST_RDB2)
			bv_q <= mem_rdata_q;
		if (state_q == ST_EXEC) begin
			res_q <= ex_res;
			onew_q <= ex_o;
			wo_q <= ex_wo;
			rem_q <= 16'd0;
			quo_q <= (op == OP_DIV) ? {av_q, 16'd0} : {16'd0, av_q};
		end
		if (state_q == ST_DIVS) begin
			rem_q <= div_ge ? 16'(div_t - {1'b0, bv_q}) : div_t[15:0];
			quo_q <= {quo_q[30:0], div_ge};
		end
		if (state_q == ST_DIVF) begin
			res_q <= (op == OP_DIV) ? quo_q[31:16] : rem_q;
			onew_q <= quo_q[15:0];
		end
	end

	// sequencer and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			for (int i = 0; i < 8; i++)
				gr_q[i] <= 16'd0;
			pc_q <= 16'd0;
			sp_q <= 16'd0;
			o_q <= 16'd0;
			opb_q <= 1'b0;
			rv_q <= 16'd0;
			skip_q <= 1'b0;
			cnt_q <= 5'd0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall && state_q != ST_DONE)
				result_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MEM_WORDS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (item_valid) begin
						rv_q <= 16'd0;
						skip_q <= 1'b0;
						case (action)
							ACT_MEM_WR: state_q <= ST_MWR;
							ACT_MEM_RD: state_q <= ST_MRD;
							ACT_REG_WR: state_q <= ST_RWR;
							ACT_REG_RD: state_q <= ST_RRD;
							ACT_EXEC:   state_q <= ST_F0;
							default:    state_q <= ST_DONE;
						endcase
					end
				end
				ST_MWR: state_q <= ST_DONE;
				ST_MRD: state_q <= ST_MRD2;
				ST_MRD2: begin
					rv_q <= mem_rdata_q;
					state_q <= ST_DONE;
				end
				ST_RWR: begin
					case (sel_q) inside
						[4'd0:4'd7]: gr_q[sel_q[2:0]] <= data_q;
						SEL_PC:      pc_q <= data_q;
						SEL_SP:      sp_q <= data_q;
						SEL_O:       o_q <= data_q;
						default:     ;
					endcase
					state_q <= ST_DONE;
				end
				ST_RRD: begin
					case (sel_q) inside
						[4'd0:4'd7]: rv_q <= gr_rd;
						SEL_PC:      rv_q <= pc_q;
						SEL_SP:      rv_q <= sp_q;
						SEL_O:       rv_q <= o_q;
						default:     rv_q <= 16'd0;
					endcase
					state_q <= ST_DONE;
				end
				ST_F0: begin
					pc_q <= pc_q + 16'd1;
					state_q <= ST_F1;
				end
				ST_F1: begin
					// non-basic words decode operand b only
					opb_q <= (mem_rdata_q[3:0] == OP_NB);
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (dec_nw) begin
						pc_q <= pc_q + 16'd1;
						state_q <= ST_NW;
					end else begin
						if (code == 6'h18)
							sp_q <= sp_q + 16'd1;
						if (code == 6'h1a)
							sp_q <= sp_q - 16'd1;
						if (!opb_q) begin
							opb_q <= 1'b1;
							state_q <= ST_DEC;
						end else begin
							state_q <= (op == OP_NB) ? ST_RDB : ST_RDA;
						end
					end
				end
				ST_NW: begin
					if (!opb_q) begin
						opb_q <= 1'b1;
						state_q <= ST_DEC;
					end else begin
						state_q <= (op == OP_NB) ? ST_RDB : ST_RDA;
					end
				end
				ST_RDA: state_q <= (kind_a_q == K_MEM) ? ST_RDA2 : ST_RDB;
				ST_RDA2: state_q <= ST_RDB;
				ST_RDB: state_q <= (kind_b_q == K_MEM) ? ST_RDB2 : ST_EXEC;
				ST_RDB2: state_q <= ST_EXEC;
				ST_EXEC: begin
					cnt_q <= 5'd0;
					case (op) inside
						OP_NB: begin
							if (ca == NB_JSR) begin
								sp_q <= sp_q - 16'd1;
								pc_q <= bv_q;
							end
							state_q <= ST_DONE;
						end
						OP_DIV, OP_MOD: state_q <= (bv_q == 16'd0) ? ST_WB : ST_DIVS;
						[OP_IFE:OP_IFB]: state_q <= ex_pass ? ST_DONE : ST_SKIP;
						default: state_q <= ST_WB;
					endcase
				end
				ST_DIVS: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31)
						state_q <= ST_DIVF;
				end
				ST_DIVF: state_q <= ST_WB;
				ST_WB: begin
					// the operand write wins over the overflow update
					if (wo_q && kind_a_q != K_O)
						o_q <= onew_q;
					case (kind_a_q)
						K_REG:   gr_q[idx_a_q[2:0]] <= res_q;
						K_SP:    sp_q <= res_q;
						K_PC:    pc_q <= res_q;
						K_O:     o_q <= res_q;
						default: ;
					endcase
					state_q <= ST_DONE;
				end
				ST_SKIP: state_q <= ST_SKIP2;
				ST_SKIP2: begin
					pc_q <= pc_q + skip_len;
					skip_q <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!result_valid_q || !result_stall)) begin
			read_value_q <= rv_q;
			program_counter_q <= pc_q;
			overflow_word_q <= o_q;
			skipped_next_q <= skip_q;
		end
	end

	assign result_valid = result_valid_q;
	assign read_value = read_value_q;
	assign program_counter = program_counter_q;
	assign overflow_word = overflow_word_q;
	assign skipped_next = skipped_next_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after an input transfer");

	a_div_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVS) |=> (state_q == ST_DIVS || state_q == ST_DIVF))
		else $error("divider left before finishing");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!result_valid_q && item_stall))
		else $error("activity during memory clearing pass");

endmodule
